// ===== hdl/lsdf_pkg.sv =====
// Package for the linear spring-damper force block.
// Holds default sizes and configuration register indexes; no dependencies.
package lsdf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REST_LEN  = 3'd5;

endpackage

// ===== hdl/lsdf_sat.sv =====
// Signed saturation from an arbitrary width into a narrower or wider signed word.
// Pure combinational; no package dependencies.
module lsdf_sat #(
    parameter int IN_W  = 64,
    parameter int OUT_W = 32
) (
    input  logic signed [IN_W-1:0]  din,
    output logic signed [OUT_W-1:0] dout
);

    localparam int XW = (IN_W > OUT_W) ? IN_W : OUT_W;
    localparam logic signed [XW-1:0] MAXV = {{(XW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [XW-1:0] MINV = ~MAXV;

    logic signed [XW-1:0] dx;

    assign dx = XW'(din);

    always_comb begin
        if (dx > MAXV) begin
            dout = OUT_W'(MAXV);
        end else if (dx < MINV) begin
            dout = OUT_W'(MINV);
        end else begin
            dout = OUT_W'(dx);
        end
    end

endmodule

// ===== hdl/lsdf_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word alongside each item; no package dependencies.
module lsdf_sqrt #(
    parameter int IN_W   = 68,
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int RW = IN_W / 2;

    logic              valid_reg [RW];
    logic [IN_W-1:0]   rem_reg   [RW];
    logic [RW-1:0]     root_reg  [RW];
    logic [SIDE_W-1:0] side_reg  [RW];

    for (genvar i = 0; i < RW; i++) begin : g_stage
        localparam int B = RW - 1 - i;
        logic [IN_W-1:0]   rem_src;
        logic [RW-1:0]     root_src;
        logic [SIDE_W-1:0] side_src;
        logic              vld_src;
        logic [IN_W:0]     trial;
        logic              take;
        logic [IN_W-1:0]   rem_next;
        logic [RW-1:0]     root_next;

        if (i == 0) begin : g_first
            assign rem_src  = in_rad;
            assign root_src = '0;
            assign side_src = in_side;
            assign vld_src  = in_valid;
        end else begin : g_next
            assign rem_src  = rem_reg[i-1];
            assign root_src = root_reg[i-1];
            assign side_src = side_reg[i-1];
            assign vld_src  = valid_reg[i-1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        assign trial = ({{(IN_W+1-RW){1'b0}}, root_src} << (B + 1))
                     | ({{IN_W{1'b0}}, 1'b1} << (2 * B));
        assign take      = {1'b0, rem_src} >= trial;
        assign rem_next  = take ? IN_W'({1'b0, rem_src} - trial) : rem_src;
        assign root_next = take ? (root_src | (RW'(1) << B)) : root_src;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (ce) begin
                valid_reg[i] <= vld_src;
            end
            if (ce) begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

// ===== hdl/lsdf_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Quotient must fit Q_W bits; carries a sideband word; no package dependencies.
module lsdf_div #(
    parameter int NUM_W  = 49,
    parameter int DEN_W  = 34,
    parameter int Q_W    = 17,
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [NUM_W-1:0]    in_num,
    input  logic [DEN_W-1:0]    in_den,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [Q_W-1:0]      out_quo,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int XW = DEN_W + Q_W;

    logic              valid_reg [Q_W];
    logic [XW-1:0]     rem_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [Q_W-1:0]    quo_reg   [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        localparam int B = Q_W - 1 - i;
        logic [XW-1:0]     rem_src;
        logic [DEN_W-1:0]  den_src;
        logic [Q_W-1:0]    quo_src;
        logic [SIDE_W-1:0] side_src;
        logic              vld_src;
        logic [XW-1:0]     dsh;
        logic              take;
        logic [XW-1:0]     rem_next;
        logic [Q_W-1:0]    quo_next;

        if (i == 0) begin : g_first
            assign rem_src  = XW'(in_num);
            assign den_src  = in_den;
            assign quo_src  = '0;
            assign side_src = in_side;
            assign vld_src  = in_valid;
        end else begin : g_next
            assign rem_src  = rem_reg[i-1];
            assign den_src  = den_reg[i-1];
            assign quo_src  = quo_reg[i-1];
            assign side_src = side_reg[i-1];
            assign vld_src  = valid_reg[i-1];
        end

        assign dsh      = XW'(den_src) << B;
        assign take     = rem_src >= dsh;
        assign rem_next = take ? (rem_src - dsh) : rem_src;
        assign quo_next = take ? (quo_src | (Q_W'(1) << B)) : quo_src;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (ce) begin
                valid_reg[i] <= vld_src;
            end
            if (ce) begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_src;
                quo_reg[i]  <= quo_next;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ===== hdl/linear_spring_damper_force_top.sv =====
// Linear spring-damper force and moment, fully pipelined.
// Depends on lsdf_pkg, lsdf_sat, lsdf_sqrt and lsdf_div.
//
//  channel   handshake          payload
//  s_        s_valid/s_ready    attach_x/y/z, vel_x/y/z (signed Q16.16)
//  m_        m_valid/m_ready    force_x/y/z, moment_x/y/z (signed Q16.16)
//  cfg_      cfg_we             cfg_idx, cfg_wdata
//
// One transaction per cycle sustained while the output is taken. The pipeline holds
// DATA_WIDTH+2 square root stages, FRAC_BITS+1 divider stages and 12 arithmetic
// stages. Reset clears valid bits and configuration registers.
// The whole pipeline advances only while the output register is empty or being
// taken, so a stall holds every stage in place.
module linear_spring_damper_force_top #(
    parameter int DATA_WIDTH = lsdf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = lsdf_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lsdf_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [DATA_WIDTH-1:0]             cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [DATA_WIDTH-1:0]      s_attach_x,
    input  logic signed [DATA_WIDTH-1:0]      s_attach_y,
    input  logic signed [DATA_WIDTH-1:0]      s_attach_z,
    input  logic signed [DATA_WIDTH-1:0]      s_vel_x,
    input  logic signed [DATA_WIDTH-1:0]      s_vel_y,
    input  logic signed [DATA_WIDTH-1:0]      s_vel_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_force_x,
    output logic signed [DATA_WIDTH-1:0]      m_force_y,
    output logic signed [DATA_WIDTH-1:0]      m_force_z,
    output logic signed [DATA_WIDTH-1:0]      m_moment_x,
    output logic signed [DATA_WIDTH-1:0]      m_moment_y,
    output logic signed [DATA_WIDTH-1:0]      m_moment_z
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int MW   = W + 1;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = SQW + 2;
    localparam int LW   = SUMW / 2;
    localparam int QW   = F + 1;
    localparam int UW   = F + 2;
    localparam int NUMW = MW + F;
    localparam int PUW  = UW + W;
    localparam int RVSW = PUW + 2;
    localparam int RVW  = RVSW - F;
    localparam int STW  = W + 3;
    localparam int KPW  = W + 1 + STW;
    localparam int CPW  = W + 1 + RVW;
    localparam int ACW  = ((KPW > CPW) ? KPW : CPW) + 2;
    localparam int SB   = ((W - 1 + F) < 62) ? (W - 1 + F) : 62;
    localparam int SW   = SB + 2;
    localparam int SHW  = (ACW > SW + 1) ? ACW : SW + 1;
    localparam int FPW  = SW + UW;
    localparam int MPW  = 2 * W;
    localparam int MSW  = MPW + 1;
    localparam int SQ_SIDE_W = 6 * W + 3 * MW + 3;
    localparam int DX_SIDE_W = 6 * W + LW + 2;

    localparam logic signed [SHW-1:0] S_POS = {{(SHW-1){1'b0}}, 1'b1} << SB;
    localparam logic signed [SHW-1:0] S_NEG = -S_POS;

    // configuration
    logic signed [W-1:0] anchor_reg [3];
    logic [W-1:0]        stiff_reg;
    logic [W-1:0]        damp_reg;
    logic [W-2:0]        rest_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                anchor_reg[i] <= '0;
            end
            stiff_reg <= '0;
            damp_reg  <= '0;
            rest_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                lsdf_pkg::REG_ANCHOR_X:  anchor_reg[0] <= cfg_wdata;
                lsdf_pkg::REG_ANCHOR_Y:  anchor_reg[1] <= cfg_wdata;
                lsdf_pkg::REG_ANCHOR_Z:  anchor_reg[2] <= cfg_wdata;
                lsdf_pkg::REG_STIFFNESS: stiff_reg     <= cfg_wdata;
                lsdf_pkg::REG_DAMPING:   damp_reg      <= cfg_wdata;
                lsdf_pkg::REG_REST_LEN:  rest_reg      <= cfg_wdata[W-2:0];
                default: ;
            endcase
        end
    end

    logic ce;
    logic m_valid_reg;

    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;

    // stage A: offset from anchor
    logic signed [W-1:0] p_in [3];
    logic signed [W-1:0] v_in [3];
    logic signed [MW-1:0] d_next [3];

    assign p_in[0] = s_attach_x;
    assign p_in[1] = s_attach_y;
    assign p_in[2] = s_attach_z;
    assign v_in[0] = s_vel_x;
    assign v_in[1] = s_vel_y;
    assign v_in[2] = s_vel_z;

    for (genvar i = 0; i < 3; i++) begin : g_diff
        assign d_next[i] = MW'(p_in[i]) - MW'(anchor_reg[i]);
    end

    logic                valid_a_reg;
    logic signed [W-1:0] p_a_reg   [3];
    logic signed [W-1:0] v_a_reg   [3];
    logic [MW-1:0]       mag_a_reg [3];
    logic                sgn_a_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
        end else if (ce) begin
            valid_a_reg <= s_valid;
        end
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                p_a_reg[i]   <= p_in[i];
                v_a_reg[i]   <= v_in[i];
                mag_a_reg[i] <= d_next[i][MW-1] ? MW'(-d_next[i]) : MW'(d_next[i]);
                sgn_a_reg[i] <= d_next[i][MW-1];
            end
        end
    end

    // stage B: squares
    logic                valid_b_reg;
    logic [SQW-1:0]      sq_b_reg  [3];
    logic signed [W-1:0] p_b_reg   [3];
    logic signed [W-1:0] v_b_reg   [3];
    logic [MW-1:0]       mag_b_reg [3];
    logic                sgn_b_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
        end else if (ce) begin
            valid_b_reg <= valid_a_reg;
        end
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                sq_b_reg[i]  <= SQW'(mag_a_reg[i]) * SQW'(mag_a_reg[i]);
                p_b_reg[i]   <= p_a_reg[i];
                v_b_reg[i]   <= v_a_reg[i];
                mag_b_reg[i] <= mag_a_reg[i];
                sgn_b_reg[i] <= sgn_a_reg[i];
            end
        end
    end

    // stage C: sum of squares
    logic                valid_c_reg;
    logic [SUMW-1:0]     sum_c_reg;
    logic signed [W-1:0] p_c_reg   [3];
    logic signed [W-1:0] v_c_reg   [3];
    logic [MW-1:0]       mag_c_reg [3];
    logic                sgn_c_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_c_reg <= 1'b0;
        end else if (ce) begin
            valid_c_reg <= valid_b_reg;
        end
        if (ce) begin
            sum_c_reg <= SUMW'(sq_b_reg[0]) + SUMW'(sq_b_reg[1]) + SUMW'(sq_b_reg[2]);
            for (int i = 0; i < 3; i++) begin
                p_c_reg[i]   <= p_b_reg[i];
                v_c_reg[i]   <= v_b_reg[i];
                mag_c_reg[i] <= mag_b_reg[i];
                sgn_c_reg[i] <= sgn_b_reg[i];
            end
        end
    end

    // spring length
    logic [SQ_SIDE_W-1:0] sq_side_in;
    logic [SQ_SIDE_W-1:0] sq_side_out;
    logic                 sq_valid;
    logic [LW-1:0]        sq_len;
    logic signed [W-1:0]  sq_p   [3];
    logic signed [W-1:0]  sq_v   [3];
    logic [MW-1:0]        sq_mag [3];
    logic                 sq_sgn [3];

    assign sq_side_in = {p_c_reg[0], p_c_reg[1], p_c_reg[2],
                         v_c_reg[0], v_c_reg[1], v_c_reg[2],
                         mag_c_reg[0], mag_c_reg[1], mag_c_reg[2],
                         sgn_c_reg[0], sgn_c_reg[1], sgn_c_reg[2]};

    assign {sq_p[0], sq_p[1], sq_p[2], sq_v[0], sq_v[1], sq_v[2],
            sq_mag[0], sq_mag[1], sq_mag[2], sq_sgn[0], sq_sgn[1], sq_sgn[2]} = sq_side_out;

    lsdf_sqrt #(
        .IN_W   (SUMW),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (valid_c_reg),
        .in_rad    (sum_c_reg),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_len),
        .out_side  (sq_side_out)
    );

    // unit direction, one divider per axis
    logic [DX_SIDE_W-1:0] dx_side_in;
    logic [DX_SIDE_W-1:0] dx_side_out;
    logic                 dv_valid [3];
    logic [QW-1:0]        dv_quo   [3];
    logic                 dv_sgn   [3];
    logic signed [W-1:0]  dv_p     [3];
    logic signed [W-1:0]  dv_v     [3];
    logic [LW-1:0]        dv_len;
    logic                 dv_zero;

    assign dx_side_in = {sq_p[0], sq_p[1], sq_p[2], sq_v[0], sq_v[1], sq_v[2],
                         sq_len, (sq_len == '0), sq_sgn[0]};

    assign {dv_p[0], dv_p[1], dv_p[2], dv_v[0], dv_v[1], dv_v[2],
            dv_len, dv_zero, dv_sgn[0]} = dx_side_out;

    lsdf_div #(
        .NUM_W  (NUMW),
        .DEN_W  (LW),
        .Q_W    (QW),
        .SIDE_W (DX_SIDE_W)
    ) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sq_valid),
        .in_num    ({sq_mag[0], {F{1'b0}}}),
        .in_den    (sq_len),
        .in_side   (dx_side_in),
        .out_valid (dv_valid[0]),
        .out_quo   (dv_quo[0]),
        .out_side  (dx_side_out)
    );

    for (genvar i = 1; i < 3; i++) begin : g_div
        lsdf_div #(
            .NUM_W  (NUMW),
            .DEN_W  (LW),
            .Q_W    (QW),
            .SIDE_W (1)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (sq_valid),
            .in_num    ({sq_mag[i], {F{1'b0}}}),
            .in_den    (sq_len),
            .in_side   (sq_sgn[i]),
            .out_valid (dv_valid[i]),
            .out_quo   (dv_quo[i]),
            .out_side  (dv_sgn[i])
        );
    end

    // stage D: signed direction, zero for a zero length
    logic signed [UW-1:0] u_next [3];

    for (genvar i = 0; i < 3; i++) begin : g_dir
        logic signed [UW-1:0] q_s;
        assign q_s       = $signed({1'b0, dv_quo[i]});
        assign u_next[i] = dv_zero ? '0 : (dv_sgn[i] ? -q_s : q_s);
    end

    logic                 valid_d_reg;
    logic signed [UW-1:0] u_d_reg [3];
    logic signed [W-1:0]  p_d_reg [3];
    logic signed [W-1:0]  v_d_reg [3];
    logic [LW-1:0]        len_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_d_reg <= 1'b0;
        end else if (ce) begin
            valid_d_reg <= dv_valid[0] && dv_valid[1] && dv_valid[2];
        end
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                u_d_reg[i] <= u_next[i];
                p_d_reg[i] <= dv_p[i];
                v_d_reg[i] <= dv_v[i];
            end
            len_d_reg <= dv_len;
        end
    end

    // stage E: u*v products and stretch
    logic signed [STW-1:0] stretch_next;

    assign stretch_next = $signed(STW'(len_d_reg)) - $signed(STW'(rest_reg));

    logic                  valid_e_reg;
    logic signed [PUW-1:0] uv_e_reg [3];
    logic signed [STW-1:0] stretch_e_reg;
    logic signed [UW-1:0]  u_e_reg  [3];
    logic signed [W-1:0]   p_e_reg  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_e_reg <= 1'b0;
        end else if (ce) begin
            valid_e_reg <= valid_d_reg;
        end
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                uv_e_reg[i] <= PUW'(u_d_reg[i]) * PUW'(v_d_reg[i]);
                u_e_reg[i]  <= u_d_reg[i];
                p_e_reg[i]  <= p_d_reg[i];
            end
            stretch_e_reg <= stretch_next;
        end
    end

    // stage F: radial velocity
    logic signed [RVSW-1:0] rv_sum;
    logic signed [RVSW-1:0] rv_sh;

    assign rv_sum = RVSW'(uv_e_reg[0]) + RVSW'(uv_e_reg[1]) + RVSW'(uv_e_reg[2]);
    assign rv_sh  = rv_sum >>> F;

    logic                  valid_f_reg;
    logic signed [RVW-1:0] rv_f_reg;
    logic signed [STW-1:0] stretch_f_reg;
    logic signed [UW-1:0]  u_f_reg [3];
    logic signed [W-1:0]   p_f_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_f_reg <= 1'b0;
        end else if (ce) begin
            valid_f_reg <= valid_e_reg;
        end
        if (ce) begin
            rv_f_reg      <= RVW'(rv_sh);
            stretch_f_reg <= stretch_e_reg;
            for (int i = 0; i < 3; i++) begin
                u_f_reg[i] <= u_e_reg[i];
                p_f_reg[i] <= p_e_reg[i];
            end
        end
    end

    // stage G: stiffness and damping terms
    logic signed [W:0] k_s;
    logic signed [W:0] c_s;

    assign k_s = $signed({1'b0, stiff_reg});
    assign c_s = $signed({1'b0, damp_reg});

    logic                  valid_g_reg;
    logic signed [KPW-1:0] kp_g_reg;
    logic signed [CPW-1:0] cp_g_reg;
    logic signed [UW-1:0]  u_g_reg [3];
    logic signed [W-1:0]   p_g_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_g_reg <= 1'b0;
        end else if (ce) begin
            valid_g_reg <= valid_f_reg;
        end
        if (ce) begin
            kp_g_reg <= KPW'(k_s) * KPW'(stretch_f_reg);
            cp_g_reg <= CPW'(c_s) * CPW'(rv_f_reg);
            for (int i = 0; i < 3; i++) begin
                u_g_reg[i] <= u_f_reg[i];
                p_g_reg[i] <= p_f_reg[i];
            end
        end
    end

    // stage H: force scalar, held to +-2^SB
    logic signed [ACW-1:0] acc;
    logic signed [ACW-1:0] acc_sh;
    logic signed [SHW-1:0] acc_x;
    logic signed [SW-1:0]  s_next;

    assign acc    = -ACW'(kp_g_reg) - ACW'(cp_g_reg);
    assign acc_sh = acc >>> F;
    assign acc_x  = SHW'(acc_sh);

    always_comb begin
        if (acc_x > S_POS) begin
            s_next = SW'(S_POS);
        end else if (acc_x < S_NEG) begin
            s_next = SW'(S_NEG);
        end else begin
            s_next = SW'(acc_x);
        end
    end

    logic                 valid_h_reg;
    logic signed [SW-1:0] s_h_reg;
    logic signed [UW-1:0] u_h_reg [3];
    logic signed [W-1:0]  p_h_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_h_reg <= 1'b0;
        end else if (ce) begin
            valid_h_reg <= valid_g_reg;
        end
        if (ce) begin
            s_h_reg <= s_next;
            for (int i = 0; i < 3; i++) begin
                u_h_reg[i] <= u_g_reg[i];
                p_h_reg[i] <= p_g_reg[i];
            end
        end
    end

    // stage I: scalar times direction
    logic                  valid_i_reg;
    logic signed [FPW-1:0] fp_i_reg [3];
    logic signed [W-1:0]   p_i_reg  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_i_reg <= 1'b0;
        end else if (ce) begin
            valid_i_reg <= valid_h_reg;
        end
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                fp_i_reg[i] <= FPW'(s_h_reg) * FPW'(u_h_reg[i]);
                p_i_reg[i]  <= p_h_reg[i];
            end
        end
    end

    // stage J: saturated force
    logic signed [W-1:0] f_next [3];

    for (genvar i = 0; i < 3; i++) begin : g_fsat
        logic signed [FPW-1:0] fp_sh;
        assign fp_sh = fp_i_reg[i] >>> F;
        lsdf_sat #(
            .IN_W  (FPW),
            .OUT_W (W)
        ) u_sat (
            .din  (fp_sh),
            .dout (f_next[i])
        );
    end

    logic                valid_j_reg;
    logic signed [W-1:0] f_j_reg [3];
    logic signed [W-1:0] p_j_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_j_reg <= 1'b0;
        end else if (ce) begin
            valid_j_reg <= valid_i_reg;
        end
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                f_j_reg[i] <= f_next[i];
                p_j_reg[i] <= p_i_reg[i];
            end
        end
    end

    // stage K: cross product terms
    logic                  valid_k_reg;
    logic signed [MPW-1:0] mp_k_reg [6];
    logic signed [W-1:0]   f_k_reg  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_k_reg <= 1'b0;
        end else if (ce) begin
            valid_k_reg <= valid_j_reg;
        end
        if (ce) begin
            mp_k_reg[0] <= MPW'(p_j_reg[1]) * MPW'(f_j_reg[2]);
            mp_k_reg[1] <= MPW'(p_j_reg[2]) * MPW'(f_j_reg[1]);
            mp_k_reg[2] <= MPW'(p_j_reg[2]) * MPW'(f_j_reg[0]);
            mp_k_reg[3] <= MPW'(p_j_reg[0]) * MPW'(f_j_reg[2]);
            mp_k_reg[4] <= MPW'(p_j_reg[0]) * MPW'(f_j_reg[1]);
            mp_k_reg[5] <= MPW'(p_j_reg[1]) * MPW'(f_j_reg[0]);
            for (int i = 0; i < 3; i++) begin
                f_k_reg[i] <= f_j_reg[i];
            end
        end
    end

    // stage L: saturated moment into the output register
    logic signed [W-1:0] m_next [3];

    for (genvar i = 0; i < 3; i++) begin : g_msat
        logic signed [MSW-1:0] md;
        logic signed [MSW-1:0] md_sh;
        assign md    = MSW'(mp_k_reg[2*i]) - MSW'(mp_k_reg[2*i+1]);
        assign md_sh = md >>> F;
        lsdf_sat #(
            .IN_W  (MSW),
            .OUT_W (W)
        ) u_sat (
            .din  (md_sh),
            .dout (m_next[i])
        );
    end

    logic signed [W-1:0] force_reg  [3];
    logic signed [W-1:0] moment_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= valid_k_reg;
        end
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                force_reg[i]  <= f_k_reg[i];
                moment_reg[i] <= m_next[i];
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_force_x  = force_reg[0];
    assign m_force_y  = force_reg[1];
    assign m_force_z  = force_reg[2];
    assign m_moment_x = moment_reg[0];
    assign m_moment_y = moment_reg[1];
    assign m_moment_z = moment_reg[2];

endmodule

// ===== hdl/lsdf_checker.sv =====
// Port-level checks for the spring-damper force block, bound to the top level.
// Depends on lsdf_pkg and on the top level's handshake and result ports.
module lsdf_checker #(
    parameter int DATA_WIDTH = lsdf_pkg::DATA_WIDTH_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic signed [DATA_WIDTH-1:0]    m_force_x,
    input logic signed [DATA_WIDTH-1:0]    m_force_y,
    input logic signed [DATA_WIDTH-1:0]    m_force_z,
    input logic signed [DATA_WIDTH-1:0]    m_moment_x,
    input logic signed [DATA_WIDTH-1:0]    m_moment_y,
    input logic signed [DATA_WIDTH-1:0]    m_moment_z
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_force_x) && $stable(m_force_y)
            && $stable(m_force_z) && $stable(m_moment_x) && $stable(m_moment_y)
            && $stable(m_moment_z))
        else $error("stalled result changed");

    // input side follows the output register
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("s_ready low with output free");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("s_ready high during output stall");

endmodule

bind linear_spring_damper_force_top lsdf_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_lsdf_checker (.*);

// ===== dv/tb_linear_spring_damper_force_top.sv =====
// Testbench for linear_spring_damper_force_top: random and directed spring evaluations,
// checked against a bit-exact fixed-point predictor in a scoreboard class.
// Depends on lsdf_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_linear_spring_damper_force_top;

    localparam int DW = lsdf_pkg::DATA_WIDTH_DEF;
    localparam int FB = lsdf_pkg::FRAC_BITS_DEF;
    localparam int IW = lsdf_pkg::CFG_IDX_W;
    localparam int LATENCY = DW + FB + 15;
    localparam int CYCLE_LIMIT = 3000000;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [DW-1:0] word_t;

    typedef struct packed {
        word_t ax, ay, az, vx, vy, vz;
    } spring_in_t;

    typedef struct packed {
        word_t fx, fy, fz, mx, my, mz;
    } wrench_t;

    class wrench_scoreboard;
        word_t anc[3];
        logic [DW-1:0] stiff, damp;
        logic [DW-2:0] rest;
        wrench_t pending[$];
        int errors;

        // registers come out of reset at zero
        function new();
            anc = '{default: '0};
            stiff = '0;
            damp = '0;
            rest = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
            case (idx)
                lsdf_pkg::REG_ANCHOR_X:  anc[0] = val;
                lsdf_pkg::REG_ANCHOR_Y:  anc[1] = val;
                lsdf_pkg::REG_ANCHOR_Z:  anc[2] = val;
                lsdf_pkg::REG_STIFFNESS: stiff = val;
                lsdf_pkg::REG_DAMPING:   damp = val;
                lsdf_pkg::REG_REST_LEN:  rest = val[DW-2:0];
                default: ;
            endcase
        endfunction

        function wide_t sat_word(wide_t x);
            wide_t y, top;
            y = x >>> FB;
            top = wide_t'(1) <<< (DW - 1);
            if (y < -top) return -top;
            if (y > top - 1) return top - 1;
            return y;
        endfunction

        function wrench_t spring_wrench(spring_in_t it);
            wide_t p[3], v[3], d[3], u[3], f[3], m[3];
            wide_t len, acc, s, smax, kw, cw, rw;
            logic [127:0] sq, root, c;
            wrench_t r;
            p[0] = wide_t'(it.ax); p[1] = wide_t'(it.ay); p[2] = wide_t'(it.az);
            v[0] = wide_t'(it.vx); v[1] = wide_t'(it.vy); v[2] = wide_t'(it.vz);
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                d[i] = p[i] - wide_t'(anc[i]);
                sq = sq + d[i] * d[i];
            end
            root = 0;
            for (int b = 62; b >= 0; b--) begin
                c = root | (128'd1 << b);
                if (c * c <= sq) root = c;
            end
            len = root;
            for (int i = 0; i < 3; i++) begin
                if (len == 0) u[i] = 0;
                else if (d[i] < 0) u[i] = -(((-d[i]) <<< FB) / len);
                else u[i] = (d[i] <<< FB) / len;
            end
            acc = 0;
            for (int i = 0; i < 3; i++) acc = acc + u[i] * v[i];
            acc = acc >>> FB;
            kw = {96'b0, stiff};
            cw = {96'b0, damp};
            rw = {97'b0, rest};
            acc = -(kw * (len - rw)) - cw * acc;
            s = acc >>> FB;
            smax = wide_t'(1) <<< (DW - 1 + FB);
            if (s < -smax) s = -smax;
            if (s > smax) s = smax;
            for (int i = 0; i < 3; i++) f[i] = sat_word(s * u[i]);
            m[0] = sat_word(p[1] * f[2] - p[2] * f[1]);
            m[1] = sat_word(p[2] * f[0] - p[0] * f[2]);
            m[2] = sat_word(p[0] * f[1] - p[1] * f[0]);
            r.fx = f[0][DW-1:0]; r.fy = f[1][DW-1:0]; r.fz = f[2][DW-1:0];
            r.mx = m[0][DW-1:0]; r.my = m[1][DW-1:0]; r.mz = m[2][DW-1:0];
            return r;
        endfunction

        function void note_input(spring_in_t it);
            pending.push_back(spring_wrench(it));
        endfunction

        function void check_result(wrench_t got);
            wrench_t e;
            if (pending.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.fx !== e.fx) begin $error("force_x exp %0d got %0d", e.fx, got.fx); errors++; end
            if (got.fy !== e.fy) begin $error("force_y exp %0d got %0d", e.fy, got.fy); errors++; end
            if (got.fz !== e.fz) begin $error("force_z exp %0d got %0d", e.fz, got.fz); errors++; end
            if (got.mx !== e.mx) begin $error("moment_x exp %0d got %0d", e.mx, got.mx); errors++; end
            if (got.my !== e.my) begin $error("moment_y exp %0d got %0d", e.my, got.my); errors++; end
            if (got.mz !== e.mz) begin $error("moment_z exp %0d got %0d", e.mz, got.mz); errors++; end
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_we;
    logic [IW-1:0] cfg_idx;
    logic [DW-1:0] cfg_wdata;
    logic s_valid, s_ready, m_valid, m_ready;
    word_t s_attach_x, s_attach_y, s_attach_z, s_vel_x, s_vel_y, s_vel_z;
    word_t m_force_x, m_force_y, m_force_z, m_moment_x, m_moment_y, m_moment_z;

    wrench_scoreboard sb;
    int idle_pct, stall_pct;
    bit hold_req;
    int unsigned cycles;

    linear_spring_damper_force_top uut (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        aresetn = 0; cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
        s_valid = 0; m_ready = 0;
        s_attach_x = 0; s_attach_y = 0; s_attach_z = 0;
        s_vel_x = 0; s_vel_y = 0; s_vel_z = 0;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (aresetn && s_valid && s_ready)
            sb.note_input({s_attach_x, s_attach_y, s_attach_z, s_vel_x, s_vel_y, s_vel_z});
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_force_x, m_force_y, m_force_z,
                             m_moment_x, m_moment_y, m_moment_z});
    end

    task automatic send_item(spring_in_t it);
        int gap;
        s_valid <= 1'b1;
        {s_attach_x, s_attach_y, s_attach_z, s_vel_x, s_vel_y, s_vel_z} <= it;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain;
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    // write all registers back to back, plus the unused indexes
    task automatic load_regs(logic [DW-1:0] vals[6]);
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= IW'(i);
            cfg_wdata <= (i < 6) ? vals[i] : $urandom();
            @(posedge aclk);
            sb.set_reg(IW'(i), (i < 6) ? vals[i] : '0);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(3))
            0: return $urandom();
            1: return word_t'($signed($urandom_range(0, 2 ** 21))) - (2 ** 20);
            2: return word_t'($signed($urandom_range(0, 2 ** 25))) - (2 ** 24);
            default: return $urandom_range(0, 1) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        endcase
    endfunction

    function automatic spring_in_t rand_item();
        spring_in_t it;
        it.ax = rand_word(); it.ay = rand_word(); it.az = rand_word();
        it.vx = rand_word(); it.vy = rand_word(); it.vz = rand_word();
        return it;
    endfunction

    initial begin
        logic [DW-1:0] regs[6];
        spring_in_t it;
        word_t mx, mn;
        sb = new();
        sb.errors = 0;
        cycles = 0;
        idle_pct = 0; stall_pct = 0; hold_req = 0;
        mx = {1'b0, {(DW-1){1'b1}}};
        mn = {1'b1, {(DW-1){1'b0}}};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed items at reset configuration, then with a moderate spring
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                regs = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                         32'h0002_0000, 32'h0000_4000, 32'h0000_8000};
                load_regs(regs);
            end
            send_item('{sb.anc[0], sb.anc[1], sb.anc[2], 32'sd5, -32'sd7, 32'sd9});
            send_item('{0, 0, 0, 0, 0, 0});
            send_item('{mx, mx, mx, mx, mx, mx});
            send_item('{mn, mn, mn, mn, mn, mn});
            send_item('{mx, mn, 0, mn, mx, 0});
            send_item('{32'sh0003_0000, 32'sh0004_0000, 0, 32'sh0001_0000, 0, 0});
            send_item('{-32'sd1, 32'sd1, 0, mx, mn, mx});
            send_item('{32'sd1, 0, 0, 0, 0, 0});
            send_item('{0, 0, -32'sh0000_8000, 0, 0, 32'sh0100_0000});
            send_item('{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                        32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001});
            drain();
        end

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: regs = '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
                1: regs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0};
                2: regs = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF, 32'h0, 32'h0};
                3: regs = '{32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
                default: begin
                    for (int i = 0; i < 6; i++) regs[i] = $urandom();
                    regs[3] = $urandom_range(0, 2 ** 20);
                    regs[4] = $urandom_range(0, 2 ** 18);
                end
            endcase
            load_regs(regs);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            for (int n = 0; n < 150; n++) begin
                if (phase == 4 && n == 20) hold_req = 1;
                it = rand_item();
                // some items near the anchor exercise tiny lengths
                if ($urandom_range(9) == 0) begin
                    it.ax = sb.anc[0] + word_t'($signed($urandom_range(0, 4))) - 2;
                    it.ay = sb.anc[1] + word_t'($signed($urandom_range(0, 4))) - 2;
                    it.az = sb.anc[2] + word_t'($signed($urandom_range(0, 4))) - 2;
                end
                send_item(it);
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lsdf_pkg.sv
hdl/lsdf_sat.sv
hdl/lsdf_sqrt.sv
hdl/lsdf_div.sv
hdl/linear_spring_damper_force_top.sv
hdl/lsdf_checker.sv
dv/tb_linear_spring_damper_force_top.sv
